// ----- rtl/core/kufa_pkg.sv -----
`default_nettype none

package kufa_pkg;

	localparam int NODE_W       = 10;
	localparam int COST_W       = 31;
	localparam int SUM_W        = 48;
	localparam int IN_TDATA_W   = 56;
	localparam int OUT_TDATA_W  = 56;
	localparam int IN_PAD_W     = IN_TDATA_W - 2 * NODE_W - COST_W;
	localparam int OUT_PAD_W    = OUT_TDATA_W - 1 - SUM_W;
	localparam int NODE_COUNT_DEF = 1024;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Datapath operations selected by the controller state.
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_INIT,
		OP_LOAD,
		OP_WALK_RD,
		OP_WALK_CHK,
		OP_CMP_RD,
		OP_CMP_CHK,
		OP_SZ_A,
		OP_SZ_B,
		OP_MERGE,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic sel_b;
	} ctrl_cmd_t;

	typedef struct packed {
		logic init_last;
		logic in_ok;
		logic at_root;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/kufa_dp.sv -----
`default_nettype none

module kufa_dp #(
	parameter int NODE_COUNT = kufa_pkg::NODE_COUNT_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  kufa_pkg::ctrl_cmd_t             cmd,
	output kufa_pkg::dp_status_t            st,
	input  wire [kufa_pkg::NODE_W-1:0]      in_node_a,
	input  wire [kufa_pkg::NODE_W-1:0]      in_node_b,
	input  wire [kufa_pkg::COST_W-1:0]      in_edge_cost,
	output logic                            out_joined,
	output logic [kufa_pkg::SUM_W-1:0]      out_total_cost
);
	import kufa_pkg::*;

	// Only the node numbers reachable through the 10-bit fields need table entries.
	localparam int DEPTH = (NODE_COUNT < (1 << NODE_W)) ? NODE_COUNT : (1 << NODE_W);
	localparam int AW    = $clog2(DEPTH);
	localparam int SZW   = $clog2(DEPTH + 1);
	localparam logic [NODE_W:0] LIMIT    = (NODE_W + 1)'(DEPTH);
	localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH - 1);

	logic [AW-1:0]     parent_mem [DEPTH];
	logic [SZW-1:0]    size_mem   [DEPTH];

	logic [AW-1:0]     prd_q;
	logic [SZW-1:0]    srd_q;
	logic [AW-1:0]     init_q;
	logic [AW-1:0]     node_a_q;
	logic [AW-1:0]     node_b_q;
	logic [COST_W-1:0] cost_q;
	logic [AW-1:0]     cur_q;
	logic [AW-1:0]     root_a_q;
	logic [AW-1:0]     root_b_q;
	logic [SZW-1:0]    size_a_q;
	logic              joined_q;
	logic [SUM_W-1:0]  cost_sum_q;

	logic              pwe;
	logic [AW-1:0]     pwaddr;
	logic [AW-1:0]     pwdata;
	logic [AW-1:0]     paddr;
	logic              swe;
	logic [AW-1:0]     swaddr;
	logic [SZW-1:0]    swdata;
	logic [AW-1:0]     saddr;
	logic [AW-1:0]     start_node;
	logic [AW-1:0]     root_sel;
	logic              differ;
	logic              a_small;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_next;

	assign start_node = cmd.sel_b ? node_b_q : node_a_q;
	assign root_sel   = cmd.sel_b ? root_b_q : root_a_q;
	assign differ     = (root_a_q != root_b_q);
	assign a_small    = (size_a_q <= srd_q);
	assign sum_ext    = {1'b0, cost_sum_q} + (SUM_W + 1)'(cost_q);
	assign sum_next   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

	always_comb begin
		st.init_last = (init_q == LAST_IDX);
		st.in_ok     = ({1'b0, in_node_a} < LIMIT) && ({1'b0, in_node_b} < LIMIT);
		case (cmd.op)
			OP_WALK_CHK: st.at_root = (prd_q == cur_q);
			OP_CMP_CHK:  st.at_root = (cur_q == root_sel);
			default:     st.at_root = 1'b0;
		endcase
	end

	always_comb begin
		pwe    = 1'b0;
		pwaddr = cur_q;
		pwdata = root_sel;
		swe    = 1'b0;
		swaddr = root_b_q;
		swdata = size_a_q + srd_q;
		paddr  = cur_q;
		saddr  = root_b_q;
		case (cmd.op)
			OP_INIT: begin
				pwe    = 1'b1;
				pwaddr = init_q;
				pwdata = init_q;
				swe    = 1'b1;
				swaddr = init_q;
				swdata = SZW'(1);
			end
			OP_WALK_RD, OP_CMP_RD: begin
				paddr = start_node;
			end
			OP_WALK_CHK: begin
				paddr = prd_q;
			end
			OP_CMP_CHK: begin
				// Point the visited node at its root and follow its old link.
				pwe   = !st.at_root;
				paddr = prd_q;
			end
			OP_SZ_A: begin
				saddr = root_a_q;
			end
			OP_MERGE: begin
				pwe = differ;
				swe = differ;
				if (a_small) begin
					pwaddr = root_a_q;
					pwdata = root_b_q;
					swaddr = root_b_q;
				end else begin
					pwaddr = root_b_q;
					pwdata = root_a_q;
					swaddr = root_a_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pwe) begin
			parent_mem[pwaddr] <= pwdata;
		end
		prd_q <= parent_mem[paddr];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			size_mem[swaddr] <= swdata;
		end
		srd_q <= size_mem[saddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= '0;
			cost_sum_q <= '0;
			joined_q   <= 1'b0;
		end else begin
			case (cmd.op)
				OP_INIT:  init_q   <= init_q + AW'(1);
				OP_LOAD:  joined_q <= 1'b0;
				OP_MERGE: begin
					joined_q <= differ;
					if (differ) begin
						cost_sum_q <= sum_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				node_a_q <= in_node_a[AW-1:0];
				node_b_q <= in_node_b[AW-1:0];
				cost_q   <= in_edge_cost;
			end
			OP_WALK_RD, OP_CMP_RD: begin
				cur_q <= start_node;
			end
			OP_WALK_CHK: begin
				if (st.at_root) begin
					if (cmd.sel_b) begin
						root_b_q <= cur_q;
					end else begin
						root_a_q <= cur_q;
					end
				end else begin
					cur_q <= prd_q;
				end
			end
			OP_CMP_CHK: begin
				cur_q <= prd_q;
			end
			OP_SZ_B: begin
				size_a_q <= srd_q;
			end
			OP_OUT: begin
				out_joined     <= joined_q;
				out_total_cost <= cost_sum_q;
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	// A node that is not the root must link somewhere else.
	a_cmp_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CMP_CHK && !st.at_root) |-> (prd_q != cur_q))
		else $error("compression step found a self link on a non-root node");

	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MERGE) |=> (cost_sum_q >= $past(cost_sum_q)))
		else $error("running total decreased");

	a_same_root_keeps_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MERGE && root_a_q == root_b_q) |=>
		(cost_sum_q == $past(cost_sum_q) && !joined_q))
		else $error("edge inside one set changed the total");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/kufa_ctrl.sv -----
`default_nettype none

module kufa_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output kufa_pkg::ctrl_cmd_t    cmd,
	input  kufa_pkg::dp_status_t   st
);
	import kufa_pkg::*;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_RD,
		ST_A_CHK,
		ST_AC_RD,
		ST_AC_CHK,
		ST_B_RD,
		ST_B_CHK,
		ST_BC_RD,
		ST_BC_CHK,
		ST_SZ_A,
		ST_SZ_B,
		ST_MERGE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   accept;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd.sel_b = 1'b0;
		case (state_q)
			ST_INIT:   cmd.op = OP_INIT;
			ST_IDLE:   cmd.op = accept ? OP_LOAD : OP_IDLE;
			ST_A_RD:   cmd.op = OP_WALK_RD;
			ST_A_CHK:  cmd.op = OP_WALK_CHK;
			ST_AC_RD:  cmd.op = OP_CMP_RD;
			ST_AC_CHK: cmd.op = OP_CMP_CHK;
			ST_B_RD: begin
				cmd.op    = OP_WALK_RD;
				cmd.sel_b = 1'b1;
			end
			ST_B_CHK: begin
				cmd.op    = OP_WALK_CHK;
				cmd.sel_b = 1'b1;
			end
			ST_BC_RD: begin
				cmd.op    = OP_CMP_RD;
				cmd.sel_b = 1'b1;
			end
			ST_BC_CHK: begin
				cmd.op    = OP_CMP_CHK;
				cmd.sel_b = 1'b1;
			end
			ST_SZ_A:   cmd.op = OP_SZ_A;
			ST_SZ_B:   cmd.op = OP_SZ_B;
			ST_MERGE:  cmd.op = OP_MERGE;
			ST_FINISH: cmd.op = out_free ? OP_OUT : OP_IDLE;
			default:   cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (st.init_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= st.in_ok ? ST_A_RD : ST_FINISH;
					end
				end
				ST_A_RD:   state_q <= ST_A_CHK;
				ST_A_CHK: begin
					if (st.at_root) begin
						state_q <= ST_AC_RD;
					end
				end
				ST_AC_RD:  state_q <= ST_AC_CHK;
				ST_AC_CHK: begin
					if (st.at_root) begin
						state_q <= ST_B_RD;
					end
				end
				ST_B_RD:   state_q <= ST_B_CHK;
				ST_B_CHK: begin
					if (st.at_root) begin
						state_q <= ST_BC_RD;
					end
				end
				ST_BC_RD:  state_q <= ST_BC_CHK;
				ST_BC_CHK: begin
					if (st.at_root) begin
						state_q <= ST_SZ_A;
					end
				end
				ST_SZ_A:   state_q <= ST_SZ_B;
				ST_SZ_B:   state_q <= ST_MERGE;
				ST_MERGE:  state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_finish_presents: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (m_tvalid_q && state_q == ST_IDLE))
		else $error("finished result was not presented");

	a_bad_edge_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !st.in_ok) |=> (state_q == ST_FINISH))
		else $error("out-of-range edge entered the root walk");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/kruskal_union_find_accumulator_top.sv -----
`default_nettype none

// Each edge walks from each endpoint to its root in the parent table and compresses
// that path, then reads both set sizes and merges. Out-of-range edges skip the walks
// and go straight to the result, with joined clear and the total unchanged.
// Throughput: edges are taken one at a time; a new edge is taken while the last result waits.
// Reset: asynchronous; afterwards a clearing pass over all min(NODE_COUNT, 1024) entries
// fills the tables, during which s_tready stays low.
module kruskal_union_find_accumulator_top #(
	parameter int NODE_COUNT = kufa_pkg::NODE_COUNT_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// node_a [9:0], node_b [19:10], edge_cost [50:20], zero pad [55:51]
	input  wire [kufa_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// joined [0], total_cost [48:1], zero pad [55:49]
	output logic [kufa_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import kufa_pkg::*;

	ctrl_cmd_t          cmd;
	dp_status_t         st;
	logic               out_joined;
	logic [SUM_W-1:0]   out_total_cost;

	kufa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	kufa_dp #(
		.NODE_COUNT (NODE_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.in_node_a      (s_tdata[NODE_W-1:0]),
		.in_node_b      (s_tdata[2*NODE_W-1:NODE_W]),
		.in_edge_cost   (s_tdata[2*NODE_W+COST_W-1:2*NODE_W]),
		.out_joined     (out_joined),
		.out_total_cost (out_total_cost)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_total_cost, out_joined};

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	import kufa_pkg::*;

	localparam int TABLE_SIZE = NODE_COUNT_DEF;
	localparam int RUN_LIMIT  = 600000;
	// Margin for the longest root walks in a union-by-size forest of 1024 nodes.
	localparam int SETTLE_CYCLES = 80;
	localparam logic [COST_W-1:0] COST_TOP = {COST_W{1'b1}};

	class spanning_tree_scoreboard;
		typedef struct {
			bit             joined;
			bit [SUM_W-1:0] total;
		} tree_result_t;

		bit [NODE_W-1:0] parent_of [TABLE_SIZE];
		bit [10:0]       members [TABLE_SIZE];
		bit [SUM_W-1:0]  tree_cost;
		tree_result_t    expected_totals [$];
		int unsigned     errors;
		int unsigned     edges_seen;
		int unsigned     joins_seen;
		int unsigned     loops_seen;
		int unsigned     results_checked;

		function new();
			for (int i = 0; i < TABLE_SIZE; i++) begin
				parent_of[i] = NODE_W'(i);
				members[i] = 11'd1;
			end
			tree_cost = '0;
			errors = 0;
			edges_seen = 0;
			joins_seen = 0;
			loops_seen = 0;
			results_checked = 0;
		endfunction

		// Walks to the root, then points every node on the path straight at it.
		function bit [NODE_W-1:0] find_root(bit [NODE_W-1:0] node);
			bit [NODE_W-1:0] r;
			bit [NODE_W-1:0] n;
			bit [NODE_W-1:0] nxt;
			int              steps;
			r = node;
			steps = 0;
			while (parent_of[r] != r && steps < TABLE_SIZE) begin
				r = parent_of[r];
				steps++;
			end
			n = node;
			steps = 0;
			while (n != r && steps < TABLE_SIZE) begin
				nxt = parent_of[n];
				parent_of[n] = r;
				n = nxt;
				steps++;
			end
			return r;
		endfunction

		function void note_edge(bit [NODE_W-1:0] a, bit [NODE_W-1:0] b, bit [COST_W-1:0] cost);
			tree_result_t    res;
			bit [NODE_W-1:0] ra;
			bit [NODE_W-1:0] rb;
			bit [SUM_W-1:0]  wide_cost;
			res.joined = 1'b0;
			wide_cost = SUM_W'(cost);
			edges_seen++;
			// With the default table size every ten-bit index is a valid node.
			if (int'(a) < TABLE_SIZE && int'(b) < TABLE_SIZE) begin
				ra = find_root(a);
				rb = find_root(b);
				if (ra != rb) begin
					if (members[ra] <= members[rb]) begin
						parent_of[ra] = rb;
						members[rb] = members[rb] + members[ra];
					end else begin
						parent_of[rb] = ra;
						members[ra] = members[ra] + members[rb];
					end
					if (tree_cost > SUM_MAX - wide_cost)
						tree_cost = SUM_MAX;
					else
						tree_cost = tree_cost + wide_cost;
					res.joined = 1'b1;
					joins_seen++;
				end else begin
					loops_seen++;
				end
			end
			res.total = tree_cost;
			expected_totals.insert(expected_totals.size(), res);
		endfunction

		task report(string msg);
			$display("[%0t] ERROR: %s", $time, msg);
			errors++;
		endtask

		task check_result(bit [OUT_TDATA_W-1:0] word);
			tree_result_t   want;
			bit             got_joined;
			bit [SUM_W-1:0] got_total;
			got_joined = word[0];
			got_total = word[SUM_W:1];
			if (expected_totals.size() == 0) begin
				report($sformatf("result %h with no edge outstanding", word));
			end else begin
				want = expected_totals.pop_front();
				results_checked++;
				if (got_joined != want.joined)
					report($sformatf("edge result %0d: joined %0b, expected %0b",
						results_checked, got_joined, want.joined));
				if (got_total != want.total)
					report($sformatf("edge result %0d: total_cost %0d, expected %0d",
						results_checked, got_total, want.total));
			end
		endtask

		function int unsigned largest_set();
			int unsigned best;
			best = 0;
			for (int i = 0; i < TABLE_SIZE; i++)
				if (parent_of[i] == NODE_W'(i) && members[i] > best)
					best = members[i];
			return best;
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycle_count = 0;
	bit [COST_W-1:0] cost_level = '0;

	spanning_tree_scoreboard tree_sb = new();

	kruskal_union_find_accumulator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tree_sb.check_result(m_tdata);
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("Run stopped after %0d cycles with %0d results still due",
			cycle_count, tree_sb.expected_totals.size());
		$display("kruskal_union_find_accumulator_top test failed");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task offer_edge(bit [NODE_W-1:0] a, bit [NODE_W-1:0] b, bit [COST_W-1:0] cost);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{IN_PAD_W{1'b0}}, cost, b, a};
		do
			@(posedge clk);
		while (!s_tready);
		tree_sb.note_edge(a, b, cost);
		@(negedge clk);
	endtask

	task pause_until_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (tree_sb.expected_totals.size() != 0)
			@(negedge clk);
	endtask

	// Mostly a rising cost sequence as a sorter would deliver, with some outliers.
	task run_phase(int unsigned count, int unsigned s_idle, int unsigned r_idle);
		bit [NODE_W-1:0] a;
		bit [NODE_W-1:0] b;
		bit [COST_W-1:0] cost;
		bit [COST_W-1:0] step;
		int              near;
		int unsigned     pick;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int unsigned i = 0; i < count; i++) begin
			a = NODE_W'($urandom_range(TABLE_SIZE - 1));
			pick = $urandom_range(99);
			if (pick < 50) begin
				b = NODE_W'($urandom_range(TABLE_SIZE - 1));
			end else if (pick < 85) begin
				near = int'(a) + int'($urandom_range(16)) - 8;
				if (near < 0)
					near = 0;
				if (near > TABLE_SIZE - 1)
					near = TABLE_SIZE - 1;
				b = NODE_W'(near);
			end else if (pick < 93) begin
				b = a;
			end else begin
				b = $urandom_range(1) ? NODE_W'(0) : NODE_W'(TABLE_SIZE - 1);
			end
			pick = $urandom_range(99);
			if (pick < 75) begin
				step = COST_W'($urandom_range(1 << 22));
				if (cost_level > COST_TOP - step)
					cost_level = COST_W'($urandom_range(1000));
				else
					cost_level = cost_level + step;
				cost = cost_level;
			end else if (pick < 95) begin
				cost = COST_W'($urandom());
			end else begin
				cost = $urandom_range(1) ? COST_TOP : '0;
			end
			offer_edge(a, b, cost);
		end
		pause_until_drained();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 15;
		recv_idle_pct = 70;

		offer_edge(10'd0, 10'd0, 31'd7);
		offer_edge(10'd0, 10'd1023, '0);
		offer_edge(10'd1023, 10'd0, COST_TOP);
		offer_edge(10'd1, 10'd2, COST_TOP);
		offer_edge(10'd3, 10'd4, 31'd1);
		// Two sets of equal size: the root of node_a goes under the other root.
		offer_edge(10'd1, 10'd3, 31'd5);
		offer_edge(10'd5, 10'd4, 31'd9);
		offer_edge(10'd4, 10'd5, 31'd9);
		offer_edge(10'd6, 10'd7, 31'd10);
		offer_edge(10'd8, 10'd9, 31'd10);
		offer_edge(10'd6, 10'd8, 31'd11);
		offer_edge(10'd9, 10'd2, 31'd12);
		offer_edge(10'd7, 10'd5, 31'd12);
		offer_edge(10'd2, 10'd2, 31'd13);
		offer_edge(10'd1023, 10'd9, 31'd14);
		offer_edge(10'h2AA, 10'h155, 31'd20);
		offer_edge(10'h155, 10'h2AA, 31'h2AAA_AAAA);
		offer_edge(10'd512, 10'd511, 31'h5555_5555);
		offer_edge(10'd511, 10'd1023, 31'h7FFF_FFFE);
		pause_until_drained();

		run_phase(400, 15, 70);
		run_phase(400, 70, 15);
		run_phase(400, 0, 0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tree_sb.expected_totals.size() != 0)
			tree_sb.report($sformatf("%0d edge results never arrived",
				tree_sb.expected_totals.size()));

		$display("Sent %0d edges: %0d joined sets, %0d closed cycles or self loops.",
			tree_sb.edges_seen, tree_sb.joins_seen, tree_sb.loops_seen);
		$display("Largest tree %0d nodes, final cost %0d, %0d results checked in %0d cycles.",
			tree_sb.largest_set(), tree_sb.tree_cost, tree_sb.results_checked, cycle_count);
		if (tree_sb.errors == 0)
			$display("kruskal_union_find_accumulator_top test passed");
		else
			$display("kruskal_union_find_accumulator_top test failed");
		$finish;
	end

endmodule
